### rtl/pfa_pkg.sv
// Package for the page frame allocator.
// Holds command, status, register index codes and the controller/datapath link types.
// No dependencies.
`default_nettype none

package pfa_pkg;

   localparam int FRAME_W  = 20;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOM  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FRAME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_FRAME = 2'd1;

   localparam logic [FRAME_W-1:0] FIRST_FRAME_RST = 20'd1024;
   localparam logic [FRAME_W-1:0] LIMIT_FRAME_RST = 20'd262144;

   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_POP  = 3'd1,
      OP_BUMP = 3'd2,
      OP_OOM  = 3'd3,
      OP_PUSH = 3'd4,
      OP_FULL = 3'd5
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic exhausted;
   } stat_type;

endpackage

`default_nettype wire

### rtl/pfa_ctrl.sv
// Controller for the page frame allocator.
// Accepts a request, picks the operation from datapath status, sequences the response.
// Depends on pfa_pkg.
`default_nettype none

module pfa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              req_command,
   input  wire pfa_pkg::stat_type stat,
   output pfa_pkg::cmd_type       cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);
   import pfa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RESP = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy       = (state_ff == ST_RESP);
   assign rsp_strobe = (state_ff == ST_RESP);
   assign accept     = start && !busy;

   always_comb begin
      cmd.load = accept;
      cmd.op   = OP_NONE;
      if (accept) begin
         if (req_command == CMD_FREE) begin
            cmd.op = stat.full ? OP_FULL : OP_PUSH;
         end else if (!stat.empty) begin
            cmd.op = OP_POP;
         end else begin
            cmd.op = stat.exhausted ? OP_OOM : OP_BUMP;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/pfa_datapath.sv
// Datapath for the page frame allocator.
// Holds the config registers, edge pointer, free stack memory and response registers.
// Depends on pfa_pkg.
`default_nettype none

module pfa_datapath #(
   parameter int FREE_DEPTH = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire pfa_pkg::cmd_type                     cmd,
   input  wire logic [pfa_pkg::FRAME_W-1:0]          req_frame_in,
   input  wire logic                                 csr_we,
   input  wire logic [pfa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [pfa_pkg::FRAME_W-1:0]          csr_wdata,
   output pfa_pkg::stat_type                         stat,
   output logic [pfa_pkg::FRAME_W-1:0]               rsp_frame_out,
   output logic [pfa_pkg::STATUS_W-1:0]              rsp_status
);
   import pfa_pkg::*;

   localparam int AW = $clog2(FREE_DEPTH);
   localparam int CW = $clog2(FREE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(FREE_DEPTH);

   logic [FRAME_W-1:0] limit_ff;
   logic [FRAME_W-1:0] edge_ff;
   logic [CW-1:0]      count_ff;
   op_type             op_ff;
   logic [FRAME_W-1:0] result_ff;
   logic [FRAME_W-1:0] rd_data_ff;
   logic [FRAME_W-1:0] mem [FREE_DEPTH];

   logic [CW-1:0]      count_dec;
   logic [FRAME_W:0]   edge_next;
   logic               do_pop;
   logic               do_push;

   assign count_dec      = count_ff - CW'(1);
   assign edge_next      = {1'b0, edge_ff} + (FRAME_W + 1)'(1);
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == DEPTH_C);
   assign stat.exhausted = (edge_next >= {1'b0, limit_ff});
   assign do_pop         = cmd.load && (cmd.op == OP_POP);
   assign do_push        = cmd.load && (cmd.op == OP_PUSH);

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[count_ff[AW-1:0]] <= req_frame_in;
      end
      if (do_pop) begin
         rd_data_ff <= mem[count_dec[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_FRAME_RST;
         edge_ff  <= FIRST_FRAME_RST;
         count_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_FIRST_FRAME: begin
                  edge_ff  <= csr_wdata;
               end
               CSR_LIMIT_FRAME: begin
                  limit_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (cmd.load) begin
            case (cmd.op)
               OP_POP:  count_ff <= count_dec;
               OP_PUSH: count_ff <= count_ff + CW'(1);
               OP_BUMP: edge_ff  <= edge_next[FRAME_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= cmd.op;
         result_ff <= edge_ff;
      end
   end

   always_comb begin
      rsp_frame_out = '0;
      rsp_status    = STATUS_OK;
      case (op_ff)
         OP_POP:  rsp_frame_out = rd_data_ff;
         OP_BUMP: rsp_frame_out = result_ff;
         OP_OOM:  rsp_status    = STATUS_OOM;
         OP_FULL: rsp_status    = STATUS_FULL;
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/page_frame_allocator.sv
// Top level of the page frame allocator.
// Joins the controller (pfa_ctrl) and the datapath (pfa_datapath); depends on pfa_pkg.
//
// Each request is transferred at an edge where start is high and busy is low, and its
// result appears on the rsp_ ports, with rsp_strobe high, for exactly the following
// cycle, during which busy is high; the next request can be taken at the edge that follows
// that cycle. Results come from registers and the free stack's registered read port, read
// at the transfer edge; the controller holds busy for the result cycle. Allocate pops the
// most recently freed frame, or else hands out the edge frame and advances it, or reports
// OOM once edge plus one reaches the limit; free pushes the frame, or reports a full
// stack. The stack needs no clearing after reset. Write csr_ registers only while idle.
`default_nettype none

module page_frame_allocator #(
   parameter int FREE_DEPTH = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_command,
   input  wire logic [pfa_pkg::FRAME_W-1:0]        req_frame_in,
   output logic                                    rsp_strobe,
   output logic [pfa_pkg::FRAME_W-1:0]             rsp_frame_out,
   output logic [pfa_pkg::STATUS_W-1:0]            rsp_status,
   input  wire logic                               csr_we,
   input  wire logic [pfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pfa_pkg::FRAME_W-1:0]        csr_wdata
);
   import pfa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pfa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe)
   );

   pfa_datapath #(
      .FREE_DEPTH (FREE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_frame_in  (req_frame_in),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .stat          (stat),
      .rsp_frame_out (rsp_frame_out),
      .rsp_status    (rsp_status)
   );

endmodule

`default_nettype wire

### rtl/pfa_checker.sv
// Port-level checker for the page frame allocator, bound to the top level.
// Depends on pfa_pkg.
`default_nettype none

module pfa_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               start,
   input wire logic                               busy,
   input wire logic                               rsp_strobe,
   input wire logic [pfa_pkg::FRAME_W-1:0]        rsp_frame_out,
   input wire logic [pfa_pkg::STATUS_W-1:0]       rsp_status
);
   import pfa_pkg::*;

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("transfer not followed by a result");

   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy))
      else $error("result without a preceding transfer");

   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      busy == rsp_strobe)
      else $error("busy and strobe disagree");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STATUS_OK) |-> (rsp_frame_out == '0))
      else $error("nonzero frame on error result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == STATUS_OK || rsp_status == STATUS_OOM ||
                      rsp_status == STATUS_FULL))
      else $error("undefined status code");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_frame_out (rsp_frame_out),
   .rsp_status    (rsp_status)
);

`default_nettype wire
